// ----- rtl/sdsc_pkg.sv -----
// sdsc_pkg: shared types and codes for the sprite depth sort and cull core
// no dependencies
`timescale 1ns / 1ps

package sdsc_pkg;

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;
   localparam logic [1:0] CMD_FRAME  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_VISIBLE   = 3'd3;
   localparam logic [2:0] ST_NONE      = 3'd4;

   // register indexes
   localparam logic [1:0] REG_SCREEN_W = 2'd0;
   localparam logic [1:0] REG_SCREEN_H = 2'd1;

   typedef struct packed {
      logic [7:0]         id;
      logic [7:0]         layer;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [11:0]        w;
      logic [11:0]        h;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_UPD_RD, S_UPD_EV, S_UPD_WR, S_UPD_NF,
      S_SORT_LD, S_SORT_RD, S_SORT_EV, S_SORT_END,
      S_CULL_ST, S_CULL_RD, S_CULL_EV, S_CULL_END
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_CLEAR, OP_APPEND, OP_FULL, OP_IDX_ZERO, OP_READ,
      OP_IDX_INC, OP_UPD_WRITE, OP_NOT_FOUND, OP_SORT_INIT, OP_SORT_LOAD,
      OP_SORT_READ, OP_SORT_EVAL, OP_SORT_END, OP_CULL_INIT, OP_CULL_EVAL,
      OP_CULL_END
   } op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       few;
      logic       at_end;
      logic       match;
      logic       visible;
      logic       pending;
      logic       slot_free;
      logic       sort_done;
   } status_type;

endpackage

// ----- rtl/sdsc_ram.sv -----
// sdsc_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module sdsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read, read data holds without rd_en
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/sdsc_ctrl.sv -----
// sdsc_ctrl: command sequencer for the sprite table
// depends on sdsc_pkg
`timescale 1ns / 1ps

module sdsc_ctrl import sdsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type stat,
   output op_type     op
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (stat.cmd)
               CMD_CLEAR, CMD_APPEND: if (stat.slot_free) state_in = S_IDLE;
               CMD_UPDATE: state_in = S_UPD_RD;
               default:    state_in = stat.few ? S_CULL_RD : S_SORT_LD;
            endcase
         end
         S_UPD_RD:   state_in = stat.at_end ? S_UPD_NF : S_UPD_EV;
         S_UPD_EV:   state_in = stat.match ? S_UPD_WR : S_UPD_RD;
         S_UPD_WR,
         S_UPD_NF:   if (stat.slot_free) state_in = S_IDLE;
         S_SORT_LD:  state_in = S_SORT_RD;
         S_SORT_RD:  state_in = S_SORT_EV;
         S_SORT_EV:  state_in = stat.sort_done ? S_SORT_END : S_SORT_RD;
         S_SORT_END: state_in = S_CULL_ST;
         S_CULL_ST:  state_in = S_CULL_RD;
         S_CULL_RD:  state_in = stat.at_end ? S_CULL_END : S_CULL_EV;
         S_CULL_EV:  begin
            if (!(stat.visible && stat.pending && !stat.slot_free)) state_in = S_CULL_RD;
         end
         S_CULL_END: if (stat.slot_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      op = OP_NONE;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) op = OP_LATCH;
         S_DISPATCH: begin
            unique case (stat.cmd)
               CMD_CLEAR:  if (stat.slot_free) op = OP_CLEAR;
               CMD_APPEND: if (stat.slot_free) op = stat.full ? OP_FULL : OP_APPEND;
               CMD_UPDATE: op = OP_IDX_ZERO;
               default:    op = stat.few ? OP_CULL_INIT : OP_SORT_INIT;
            endcase
         end
         S_UPD_RD:   if (!stat.at_end) op = OP_READ;
         S_UPD_EV:   if (!stat.match) op = OP_IDX_INC;
         S_UPD_WR:   if (stat.slot_free) op = OP_UPD_WRITE;
         S_UPD_NF:   if (stat.slot_free) op = OP_NOT_FOUND;
         S_SORT_LD:  op = OP_SORT_LOAD;
         S_SORT_RD:  op = OP_SORT_READ;
         S_SORT_EV:  op = OP_SORT_EVAL;
         S_SORT_END: op = OP_SORT_END;
         S_CULL_ST:  op = OP_CULL_INIT;
         S_CULL_RD:  if (!stat.at_end) op = OP_READ;
         S_CULL_EV:  begin
            if (!(stat.visible && stat.pending && !stat.slot_free)) op = OP_CULL_EVAL;
         end
         S_CULL_END: if (stat.slot_free) op = OP_CULL_END;
         default:    op = OP_NONE;
      endcase
   end

endmodule

// ----- rtl/sdsc_dp.sv -----
// sdsc_dp: sprite table datapath: table ram, sort carry register, cull logic
// depends on sdsc_pkg and sdsc_ram
`timescale 1ns / 1ps

module sdsc_dp import sdsc_pkg::*; #(
   parameter int MAX_SPRITES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  op_type       op,
   output status_type   stat,
   input  logic [1:0]   req_cmd,
   input  logic [103:0] req_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [14:0]  csr_data,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_id,
   output logic [2:0]   rsp_status,
   output logic         rsp_last
);

   localparam int IW = $clog2(MAX_SPRITES + 1);
   localparam int AW = $clog2(MAX_SPRITES);
   localparam logic [IW-1:0] CAP = IW'(MAX_SPRITES);
   localparam logic [IW-1:0] ONE = IW'(1);

   logic [1:0]        cmd_ff, cmd_in;
   entry_type         req_ff, req_in;
   logic signed [15:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [IW-1:0]     count_ff, count_in, idx_ff, idx_in;
   logic              dir_ff, dir_in;
   entry_type         cur_ff, cur_in;
   logic              pend_ff, pend_in;
   logic [7:0]        pend_id_ff, pend_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_id_ff, rsp_id_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [14:0]       scr_w_ff, scr_w_in, scr_h_ff, scr_h_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   entry_type         wr_data, rd;
   logic [ENTRY_W-1:0] rd_raw;

   logic [IW-1:0]     idx_step, sort_start;
   logic              slot_free, visible, keep_cur, cur_gt, cur_lt;
   logic signed [16:0] bot_cur, bot_rd, right_e, lower_e, rd_x17, rd_y17, rd_r17;

   sdsc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPRITES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd = entry_type'(rd_raw);

   // sort key compare: layer first, then bottom edge
   assign bot_cur = 17'(cur_ff.y) + $signed({5'b0, cur_ff.h});
   assign bot_rd  = 17'(rd.y) + $signed({5'b0, rd.h});
   assign cur_gt  = (cur_ff.layer > rd.layer) ||
                    ((cur_ff.layer == rd.layer) && (bot_cur > bot_rd));
   assign cur_lt  = (cur_ff.layer < rd.layer) ||
                    ((cur_ff.layer == rd.layer) && (bot_cur < bot_rd));
   assign keep_cur = dir_ff ? cur_lt : cur_gt;

   // window overlap test in 17-bit signed
   assign right_e = 17'(sx_ff) + $signed({2'b0, scr_w_ff});
   assign lower_e = 17'(sy_ff) + $signed({2'b0, scr_h_ff});
   assign rd_x17  = 17'(rd.x);
   assign rd_y17  = 17'(rd.y);
   assign rd_r17  = rd_x17 + $signed({5'b0, rd.w});
   assign visible = (rd_x17 < right_e) && (rd_y17 < lower_e) &&
                    (rd_r17 > 17'(sx_ff)) && (bot_rd > 17'(sy_ff));

   assign idx_step   = dir_ff ? idx_ff - ONE : idx_ff + ONE;
   assign sort_start = dir_ff ? count_ff - ONE : '0;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // status to controller
   always_comb begin
      stat.cmd       = cmd_ff;
      stat.full      = (count_ff >= CAP);
      stat.few       = (count_ff < IW'(2));
      stat.at_end    = (idx_ff == count_ff);
      stat.match     = (rd.id == req_ff.id);
      stat.visible   = visible;
      stat.pending   = pend_ff;
      stat.slot_free = slot_free;
      stat.sort_done = dir_ff ? (idx_ff == '0) : (idx_ff == count_ff - ONE);
   end

   // operation decode
   always_comb begin
      cmd_in = cmd_ff;
      req_in = req_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      dir_in = dir_ff;
      cur_in = cur_ff;
      pend_in = pend_ff;
      pend_id_in = pend_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in = rsp_last_ff;
      scr_w_in = scr_w_ff;
      scr_h_in = scr_h_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = cur_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      if (csr_we) begin
         if (csr_index == REG_SCREEN_W) scr_w_in = csr_data;
         if (csr_index == REG_SCREEN_H) scr_h_in = csr_data;
      end
      unique case (op)
         OP_LATCH: begin
            // unpack the request beat, sprite id in the lowest bits
            cmd_in = req_cmd;
            req_in.id = req_data[7:0];
            req_in.layer = req_data[15:8];
            req_in.x = req_data[31:16];
            req_in.y = req_data[47:32];
            req_in.w = req_data[59:48];
            req_in.h = req_data[71:60];
            sx_in = req_data[87:72];
            sy_in = req_data[103:88];
         end
         OP_CLEAR: begin
            count_in = '0;
            {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} = {1'b1, 8'd0, ST_OK, 1'b1};
         end
         OP_APPEND: begin
            wr_en = 1'b1;
            wr_addr = count_ff[AW-1:0];
            wr_data = req_ff;
            count_in = count_ff + ONE;
            {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} = {1'b1, 8'd0, ST_OK, 1'b1};
         end
         OP_FULL: begin
            {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} = {1'b1, 8'd0, ST_FULL, 1'b1};
         end
         OP_IDX_ZERO: idx_in = '0;
         OP_READ:     rd_en = 1'b1;
         OP_IDX_INC:  idx_in = idx_ff + ONE;
         OP_UPD_WRITE: begin
            wr_en = 1'b1;
            wr_data = req_ff;
            {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} = {1'b1, 8'd0, ST_OK, 1'b1};
         end
         OP_NOT_FOUND: begin
            {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} =
               {1'b1, 8'd0, ST_NOT_FOUND, 1'b1};
         end
         OP_SORT_INIT: begin
            idx_in = sort_start;
            rd_en = 1'b1;
            rd_addr = sort_start[AW-1:0];
         end
         OP_SORT_LOAD: begin
            cur_in = rd;
            idx_in = idx_step;
         end
         OP_SORT_READ: rd_en = 1'b1;
         OP_SORT_EVAL: begin
            // write settled entry behind carry, carry larger up, smaller down
            wr_en = 1'b1;
            wr_addr = dir_ff ? (idx_ff[AW-1:0] + 1'b1) : (idx_ff[AW-1:0] - 1'b1);
            if (keep_cur) begin
               wr_data = rd;
            end else begin
               wr_data = cur_ff;
               cur_in = rd;
            end
            if (!stat.sort_done) idx_in = idx_step;
         end
         OP_SORT_END: begin
            wr_en = 1'b1;
            dir_in = !dir_ff;
         end
         OP_CULL_INIT: begin
            idx_in = '0;
            pend_in = 1'b0;
         end
         OP_CULL_EVAL: begin
            // hold one visible id back so the last one can be marked
            if (visible) begin
               if (pend_ff) begin
                  {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} =
                     {1'b1, pend_id_ff, ST_VISIBLE, 1'b0};
               end
               pend_in = 1'b1;
               pend_id_in = rd.id;
            end
            idx_in = idx_ff + ONE;
         end
         OP_CULL_END: begin
            if (pend_ff) begin
               {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} =
                  {1'b1, pend_id_ff, ST_VISIBLE, 1'b1};
            end else begin
               {rsp_valid_in, rsp_id_in, rsp_status_in, rsp_last_in} =
                  {1'b1, 8'd0, ST_NONE, 1'b1};
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dir_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         cmd_ff <= CMD_CLEAR;
         idx_ff <= '0;
         scr_w_ff <= 15'd1024;
         scr_h_ff <= 15'd512;
      end else begin
         count_ff <= count_in;
         dir_ff <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
         cmd_ff <= cmd_in;
         idx_ff <= idx_in;
         scr_w_ff <= scr_w_in;
         scr_h_ff <= scr_h_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      cur_ff <= cur_in;
      pend_id_ff <= pend_id_in;
      rsp_id_ff <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_id = rsp_id_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ----- rtl/sprite_depth_sort_cull_core.sv -----
// sprite_depth_sort_cull_core: top level, joins sequencer and datapath
// depends on sdsc_pkg, sdsc_ctrl, sdsc_dp, sdsc_ram
`timescale 1ns / 1ps

// Ordered sprite table of up to MAX_SPRITES entries held in one ram. One command
// is worked at a time. Clear, append and update each return one beat; update
// scans the table entry by entry until the first id match. A frame with n >= 2
// entries runs one shaker pass in alternating direction (one ram read port, one
// write port, the moving entry held in a register), then culls against the
// window; a frame with fewer entries goes straight to the cull. Visible ids leave
// in table order, the final one with tlast set; with nothing visible a single
// status-4 beat is returned. Each result beat sits in an output register so the
// core keeps working while it waits to be taken, until the next beat is due. No
// reset sweep: the table is read only below its fill count.

module sprite_depth_sort_cull_core import sdsc_pkg::*; #(
   parameter int MAX_SPRITES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sprite_id[7:0] layer[15:8] pos_x[31:16] pos_y[47:32] size_w[59:48]
   // size_h[71:60] scroll_x[87:72] scroll_y[103:88]
   input  logic [103:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_id[7:0]
   output logic [7:0]   rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [14:0]  csr_data
);

   op_type     op;
   status_type stat;

   assign csr_ready = 1'b1;

   sdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .op        (op)
   );

   sdsc_dp #(.MAX_SPRITES(MAX_SPRITES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .stat      (stat),
      .req_cmd   (req_tuser),
      .req_data  (req_tdata),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_id    (rsp_tdata),
      .rsp_status(rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   // one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a command is in progress");

   // only visible-id beats may be non-final
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_VISIBLE) |-> rsp_tlast)
      else $error("non-visible status without last");

   // a valid beat never carries a reserved status code
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_FULL ||
                      rsp_tuser == ST_NOT_FOUND || rsp_tuser == ST_VISIBLE ||
                      rsp_tuser == ST_NONE))
      else $error("result status out of range");

endmodule
